// ===== sv/swdtl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the switch debounce and toggle latch block.
// No dependencies.
package swdtl_pkg;

	localparam int SW_COUNT          = 5;
	localparam int NOW_W             = 32;
	localparam int DEBOUNCE_W        = 16;
	localparam int TIME_BITS_DEFAULT = 32;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;

	// one bit per switch; head is the most significant bit
	typedef struct packed {
		logic head;
		logic park;
		logic left;
		logic right;
		logic hazard;
	} sw_vec_t;

endpackage

// ===== sv/swdtl_lane.sv =====
`timescale 1ns / 1ps
// One debouncer lane: sample, change time and stable level of a single switch.
// Depends on swdtl_pkg.
module swdtl_lane #(
	parameter int TIME_BITS = swdtl_pkg::TIME_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             pressed,
	input  logic [TIME_BITS-1:0]             now,
	input  logic [swdtl_pkg::DEBOUNCE_W-1:0] debounce_ms,
	output logic                             press_event
);
	import swdtl_pkg::*;

	logic                 last_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] change_q;

	logic                 changed;
	logic [TIME_BITS-1:0] change_time;
	logic [TIME_BITS-1:0] elapsed;
	logic                 ripe;
	logic                 update;

	assign changed     = pressed != last_q;
	assign change_time = changed ? now : change_q;
	assign elapsed     = now - change_time;
	assign ripe        = elapsed >= TIME_BITS'(debounce_ms);
	assign update      = ripe && (stable_q != pressed);
	assign press_event = update && pressed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			stable_q <= 1'b0;
			change_q <= '0;
		end else if (en) begin
			last_q   <= pressed;
			change_q <= change_time;
			if (update) begin
				stable_q <= pressed;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		press_event |-> (pressed && !stable_q))
	else $error("press event without a rising stable level");

	assert property (@(posedge clk) disable iff (!arst_n)
		(en && changed && (debounce_ms != '0)) |=> (stable_q == $past(stable_q)))
	else $error("stable level moved on a fresh change with nonzero debounce");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) |-> ($stable(last_q) && $stable(stable_q)))
	else $error("lane state moved without an accepted item");

endmodule

// ===== sv/swdtl_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: applies the press events of all lanes to the latch bits.
// Depends on swdtl_pkg.
module swdtl_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  swdtl_pkg::sw_vec_t ev,
	output swdtl_pkg::sw_vec_t latch
);
	import swdtl_pkg::*;

	sw_vec_t latch_q;
	sw_vec_t latch_d;

	always_comb begin
		latch_d = latch_q;
		if (ev.head) begin
			latch_d.head = ~latch_d.head;
		end
		if (ev.park) begin
			latch_d.park = ~latch_d.park;
		end
		if (ev.hazard) begin
			if (!latch_d.hazard) begin
				latch_d.hazard = 1'b1;
				latch_d.left   = 1'b0;
				latch_d.right  = 1'b0;
			end else begin
				latch_d.hazard = 1'b0;
			end
		end
		if (!latch_d.hazard) begin
			if (ev.left) begin
				if (!latch_d.left) begin
					latch_d.left  = 1'b1;
					latch_d.right = 1'b0;
				end else begin
					latch_d.left = 1'b0;
				end
			end
			if (ev.right) begin
				if (!latch_d.right) begin
					latch_d.right = 1'b1;
					latch_d.left  = 1'b0;
				end else begin
					latch_d.right = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
		end else if (en) begin
			latch_q <= latch_d;
		end
	end

	assign latch = latch_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!(latch_q.left && latch_q.right))
	else $error("left and right latches both on");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(latch_q.hazard) |-> (!latch_q.left && !latch_q.right))
	else $error("hazard set without clearing indicators");

	assert property (@(posedge clk) disable iff (!arst_n)
		(latch_q.hazard && $past(latch_q.hazard)) |-> (!latch_q.left && !latch_q.right))
	else $error("indicator latched while hazard on");

endmodule

// ===== sv/switch_debounce_toggle_latch.sv =====
`timescale 1ns / 1ps
// Top level: five debouncer lanes, the latch merge stage and the output handshake.
// Depends on swdtl_pkg, swdtl_lane and swdtl_merge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one poll: five active-low switch
//   levels and a millisecond timestamp. Output channel (out_valid/out_ready)
//   carries the five latch bits after that poll.
//   cfg_we/cfg_wdata write the debounce time in ms; write only while idle.
//   Latency: the result is valid the cycle after the poll is accepted.
//   Throughput: one poll per cycle unless stalled. All five lanes compare
//   their elapsed time (one TIME_BITS subtract and compare each) in parallel,
//   and the merge stage folds the events into the latches in the same cycle.
//   Stall: the result register holds its item while out_ready is low; a new
//   poll is taken only in a cycle where the held result leaves or none waits.
//   Reset: samples, stable levels, change times and latches clear to zero,
//   debounce time returns to 30 ms, no result is pending.
module switch_debounce_toggle_latch #(
	parameter int TIME_BITS = swdtl_pkg::TIME_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swdtl_pkg::DEBOUNCE_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             head_level,
	input  logic                             park_level,
	input  logic                             left_level,
	input  logic                             right_level,
	input  logic                             hazard_level,
	input  logic [swdtl_pkg::NOW_W-1:0]      now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             head_on,
	output logic                             park_on,
	output logic                             left_on,
	output logic                             right_on,
	output logic                             hazard_on
);
	import swdtl_pkg::*;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic                  out_valid_q;
	logic                  accept;
	logic [TIME_BITS-1:0]  now_t;
	logic [SW_COUNT-1:0]   pressed;
	logic [SW_COUNT-1:0]   ev_bits;
	sw_vec_t               latch;

	generate
		if (TIME_BITS > NOW_W) begin : g_wide
			assign now_t = {{(TIME_BITS - NOW_W){1'b0}}, now_ms};
		end else if (TIME_BITS == NOW_W) begin : g_same
			assign now_t = now_ms;
		end else begin : g_narrow
			assign now_t = now_ms[TIME_BITS-1:0];
		end
	endgenerate

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign pressed  = ~{head_level, park_level, left_level, right_level, hazard_level};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_wdata;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	generate
		for (genvar i = 0; i < SW_COUNT; i++) begin : g_lane
			swdtl_lane #(
				.TIME_BITS(TIME_BITS)
			) u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (accept),
				.pressed    (pressed[i]),
				.now        (now_t),
				.debounce_ms(debounce_q),
				.press_event(ev_bits[i])
			);
		end
	endgenerate

	swdtl_merge u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (accept),
		.ev    (sw_vec_t'(ev_bits)),
		.latch (latch)
	);

	assign out_valid = out_valid_q;
	assign head_on   = latch.head;
	assign park_on   = latch.park;
	assign left_on   = latch.left;
	assign right_on  = latch.right;
	assign hazard_on = latch.hazard;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
	else $error("accepted item produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(latch)))
	else $error("held result changed under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
	else $error("poll taken while result blocked");

endmodule
